// ===== rtl/sprs_pkg.sv =====
// Package for the servo pulse ramp sequencer: widths, command codes,
// configuration register indexes and reset values. No dependencies.
package sprs_pkg;

  // State and width field sizes in bits
  localparam int unsigned WidthBits = 18;
  localparam int unsigned HoldBits  = 16;
  localparam int unsigned RepBits   = 8;
  localparam int unsigned RepsBits  = RepBits + 1;
  localparam int unsigned CmdBits   = 2;
  localparam int unsigned CfgIdxBits  = 3;
  localparam int unsigned CfgDataBits = WidthBits;

  typedef logic [WidthBits-1:0] width_t;
  typedef logic [HoldBits-1:0]  hold_t;
  typedef logic [RepBits-1:0]   rep_t;
  typedef logic [RepsBits-1:0]  reps_t;

  // Input commands
  typedef enum logic [CmdBits-1:0] {
    CMD_TICK   = 2'd0,
    CMD_START  = 2'd1,
    CMD_PRESET = 2'd2
  } cmd_e;

  // Configuration register indexes
  typedef enum logic [CfgIdxBits-1:0] {
    REG_PERIOD = 3'd0,
    REG_STEP   = 3'd1,
    REG_HOLD   = 3'd2,
    REG_MIN    = 3'd3,
    REG_MAX    = 3'd4,
    REG_FIRST  = 3'd5,
    REG_SECOND = 3'd6,
    REG_REPEAT = 3'd7
  } reg_idx_e;

  // Register reset values
  localparam width_t RstPeriod = width_t'(100000);
  localparam width_t RstStep   = width_t'(100);
  localparam hold_t  RstHold   = hold_t'(25);
  localparam width_t RstMin    = width_t'(5000);
  localparam width_t RstMax    = width_t'(10000);
  localparam width_t RstFirst  = width_t'(7500);
  localparam width_t RstSecond = width_t'(0);
  localparam rep_t   RstRepeat = rep_t'(1);

endpackage

// ===== rtl/sprs_if.sv =====
// Valid/ready channel interfaces for the servo pulse ramp sequencer.
// Depends on sprs_pkg for field widths.
interface sprs_in_if import sprs_pkg::*; ();
  logic         valid;
  logic         ready;
  logic [CmdBits-1:0] cmd;
  width_t       position_clks;

  modport source (output valid, output cmd, output position_clks, input ready);
  modport sink   (input valid, input cmd, input position_clks, output ready);
endinterface

interface sprs_out_if import sprs_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   pin_level;
  logic   running;
  width_t actual_width_clks;
  width_t target_width_clks;

  modport source (output valid, output pin_level, output running,
                  output actual_width_clks, output target_width_clks, input ready);
  modport sink   (input valid, input pin_level, input running,
                  input actual_width_clks, input target_width_clks, output ready);
endinterface

// ===== rtl/servo_pulse_ramp_sequencer_unit.sv =====
// Servo pulse generator with slew-rate limited width ramp and target alternation.
// Flow: a beat accepted into the input register moves into the result register
//   when the result register is empty or its beat is being taken.
// Throughput: one beat per cycle unless the output stalls; the state update is a
//   combinational pass (one subtract/compare/add for the ramp) between registers.
// Reset (rst_ni low, async): sequencer idle, pin low, all widths and counters
//   zero, configuration registers at their defaults, both stages empty.
module servo_pulse_ramp_sequencer_unit import sprs_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  sprs_in_if.sink                in_i,
  sprs_out_if.source             out_o,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [CfgDataBits-1:0] cfg_data_i
);

  // Configuration registers
  width_t period_q, step_q, min_q, max_q, first_q, second_q;
  hold_t  hold_cfg_q;
  rep_t   repeat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q   <= RstPeriod;
      step_q     <= RstStep;
      hold_cfg_q <= RstHold;
      min_q      <= RstMin;
      max_q      <= RstMax;
      first_q    <= RstFirst;
      second_q   <= RstSecond;
      repeat_q   <= RstRepeat;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_PERIOD: period_q   <= cfg_data_i;
        REG_STEP:   step_q     <= cfg_data_i;
        REG_HOLD:   hold_cfg_q <= cfg_data_i[HoldBits-1:0];
        REG_MIN:    min_q      <= cfg_data_i;
        REG_MAX:    max_q      <= cfg_data_i;
        REG_FIRST:  first_q    <= cfg_data_i;
        REG_SECOND: second_q   <= cfg_data_i;
        REG_REPEAT: repeat_q   <= cfg_data_i[RepBits-1:0];
        default:    ;
      endcase
    end
  end

  // Pipeline handshake
  logic         in_v_q, out_v_q;
  logic [CmdBits-1:0] cmd_q;
  width_t       pos_q;
  logic         adv;

  assign adv        = !out_v_q || out_o.ready;
  assign in_i.ready = !in_v_q || adv;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_i.ready) begin
      in_v_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      cmd_q <= in_i.cmd;
      pos_q <= in_i.position_clks;
    end
  end

  // Sequencer state
  width_t cnt_q, cnt_d, nload_q, nload_d, act_q, act_d, tgt_q, tgt_d;
  hold_t  hold_q, hold_d;
  reps_t  rep_q, rep_d;
  logic   pin_q, pin_d, active_q, active_d;

  // Shared arithmetic
  width_t diff, move, act_ramp, nl_evt, start_cnt, preset_w;
  hold_t  hold_dec;
  reps_t  rep_dec;
  logic   ramp_up;

  always_comb begin
    ramp_up   = tgt_q > act_q;
    diff      = ramp_up ? (tgt_q - act_q) : (act_q - tgt_q);
    move      = (diff > step_q) ? step_q : diff;
    act_ramp  = ramp_up ? (act_q + move) : (act_q - move);
    nl_evt    = (period_q > nload_q) ? (period_q - nload_q) : '0;
    start_cnt = (period_q > act_q) ? (period_q - act_q) : '0;
    hold_dec  = hold_q - hold_t'(1);
    rep_dec   = rep_q - reps_t'(1);
    if (pos_q < min_q) begin
      preset_w = min_q;
    end else if (pos_q > max_q) begin
      preset_w = max_q;
    end else begin
      preset_w = pos_q;
    end
  end

  // Next-state logic for one beat
  always_comb begin
    cnt_d    = cnt_q;
    nload_d  = nload_q;
    act_d    = act_q;
    tgt_d    = tgt_q;
    hold_d   = hold_q;
    rep_d    = rep_q;
    pin_d    = pin_q;
    active_d = active_q;
    unique case (cmd_e'(cmd_q))
      CMD_TICK: begin
        if (active_q) begin
          if (cnt_q > width_t'(1)) begin
            cnt_d = cnt_q - width_t'(1);
          end else begin
            // Timer event: reload and toggle the pin
            cnt_d   = nload_q;
            pin_d   = !pin_q;
            nload_d = nl_evt;
            if (pin_q) begin
              // Falling edge: ramp, then hold, then alternate
              if (tgt_q != act_q) begin
                act_d   = act_ramp;
                nload_d = act_ramp;
                if (act_ramp == tgt_q) hold_d = hold_cfg_q;
              end else if (hold_q != '0) begin
                hold_d = hold_dec;
                if (hold_dec == '0) begin
                  if (rep_q <= reps_t'(1)) begin
                    rep_d    = '0;
                    active_d = 1'b0;
                  end else begin
                    rep_d = rep_dec;
                    tgt_d = rep_dec[0] ? second_q : first_q;
                  end
                end
              end
            end
          end
        end
      end
      CMD_START: begin
        tgt_d    = first_q;
        rep_d    = (second_q == '0) ? reps_t'(1) : {repeat_q, 1'b0};
        nload_d  = act_q;
        cnt_d    = start_cnt;
        pin_d    = 1'b0;
        hold_d   = '0;
        active_d = 1'b1;
      end
      CMD_PRESET: begin
        act_d = preset_w;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      nload_q  <= '0;
      act_q    <= '0;
      tgt_q    <= '0;
      hold_q   <= '0;
      rep_q    <= '0;
      pin_q    <= 1'b0;
      active_q <= 1'b0;
    end else if (adv && in_v_q) begin
      cnt_q    <= cnt_d;
      nload_q  <= nload_d;
      act_q    <= act_d;
      tgt_q    <= tgt_d;
      hold_q   <= hold_d;
      rep_q    <= rep_d;
      pin_q    <= pin_d;
      active_q <= active_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= in_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_v_q) begin
      out_o.pin_level         <= pin_d;
      out_o.running           <= active_d;
      out_o.actual_width_clks <= act_d;
      out_o.target_width_clks <= tgt_d;
    end
  end

  assign out_o.valid = out_v_q;

endmodule

// ===== rtl/sprs_checker.sv =====
// Port-level checks for servo_pulse_ramp_sequencer_unit, bound into that unit.
// Depends on sprs_pkg for widths.
module sprs_checker import sprs_pkg::*; (
  input logic   clk_i,
  input logic   rst_ni,
  input logic   in_valid_i,
  input logic   in_ready_i,
  input logic   out_valid_i,
  input logic   out_ready_i,
  input logic   pin_level_i,
  input logic   running_i,
  input width_t actual_width_clks_i,
  input width_t target_width_clks_i
);

  // A stalled result beat holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(pin_level_i)
      && $stable(running_i) && $stable(actual_width_clks_i)
      && $stable(target_width_clks_i))
    else $error("stalled result beat changed");

  // The pin only stops low
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !running_i |-> !pin_level_i)
    else $error("pin high while sequencer idle");

  // A draining output never stalls the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_i)
    else $error("input stalled while output drains");

  // An accepted beat leaves the result register valid after the next edge (it or an earlier stalled beat)
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |-> ##2 out_valid_i)
    else $error("result beat missing after accepted input");

endmodule

bind servo_pulse_ramp_sequencer_unit sprs_checker u_sprs_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_valid_i          (in_i.valid),
  .in_ready_i          (in_i.ready),
  .out_valid_i         (out_o.valid),
  .out_ready_i         (out_o.ready),
  .pin_level_i         (out_o.pin_level),
  .running_i           (out_o.running),
  .actual_width_clks_i (out_o.actual_width_clks),
  .target_width_clks_i (out_o.target_width_clks)
);

// ===== sim/servo_pulse_ramp_sequencer_unit_test.sv =====
// Self-checking testbench for servo_pulse_ramp_sequencer_unit: runs directed and
// random command beats, predicts each result beat, and compares it in order.
// Depends on sprs_pkg, the sprs_in_if/sprs_out_if interfaces and the unit itself.
`timescale 1ns / 100ps

module servo_pulse_ramp_sequencer_unit_test;
  import sprs_pkg::*;

  localparam logic [CmdBits-1:0] CmdIgnored = 2'd3;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned TotalBeats = 650;

  typedef struct packed {
    logic   pin;
    logic   running;
    width_t actual;
    width_t target;
  } servo_beat_t;

  typedef struct packed {
    width_t period_w;
    width_t step_w;
    hold_t  hold_n;
    width_t min_w;
    width_t max_w;
    width_t first_w;
    width_t second_w;
    rep_t   pair_n;
  } servo_cfg_t;

  typedef enum logic [1:0] {SINK_OPEN, SINK_BUSY, SINK_SLOW} sink_mode_e;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CfgIdxBits-1:0]  cfg_idx_i;
  logic [CfgDataBits-1:0] cfg_data_i;

  sprs_in_if  in_ch ();
  sprs_out_if out_ch ();

  servo_pulse_ramp_sequencer_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_ch),
    .out_o      (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Predicted servo state and register copy
  servo_cfg_t cfg_now;
  width_t     cd_q, next_load_q, actual_q, target_q;
  hold_t      hold_left_q;
  reps_t      pairs_left_q;
  logic       pin_q, active_q;

  servo_beat_t awaited_servo_states[$];
  int unsigned mismatch_count;
  int unsigned beats_sent;
  int unsigned cycle_count;
  int unsigned burst_left;
  int unsigned hold_off_left;
  bit          gaps_on;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count > CycleLimit);
    $display("Mismatches found");
    $finish;
  end

  function automatic width_t period_less(input width_t v);
    return (cfg_now.period_w > v) ? width_t'(cfg_now.period_w - v) : '0;
  endfunction

  // Advance the predicted state by one beat and return the state it shows
  function automatic servo_beat_t step_servo(input logic [CmdBits-1:0] cmd,
                                             input width_t pos);
    width_t      gap_w;
    width_t      clamped;
    servo_beat_t r;
    case (cmd)
      CMD_TICK: begin
        if (active_q) begin
          if (cd_q > 1) begin
            cd_q = cd_q - 1'b1;
          end else begin
            cd_q        = next_load_q;
            pin_q       = ~pin_q;
            next_load_q = period_less(next_load_q);
            // falling edge: ramp first, then hold, then alternate targets
            if (!pin_q) begin
              if (target_q != actual_q) begin
                gap_w = (target_q > actual_q) ? target_q - actual_q : actual_q - target_q;
                if (gap_w > cfg_now.step_w) gap_w = cfg_now.step_w;
                actual_q    = (target_q > actual_q) ? actual_q + gap_w : actual_q - gap_w;
                next_load_q = actual_q;
                if (target_q == actual_q) hold_left_q = cfg_now.hold_n;
              end else if (hold_left_q != 0) begin
                hold_left_q = hold_left_q - 1'b1;
                if (hold_left_q == 0) begin
                  if (pairs_left_q <= 1) begin
                    pairs_left_q = '0;
                    active_q     = 1'b0;
                  end else begin
                    pairs_left_q = pairs_left_q - 1'b1;
                    target_q     = pairs_left_q[0] ? cfg_now.second_w : cfg_now.first_w;
                  end
                end
              end
            end
          end
        end
      end
      CMD_START: begin
        target_q     = cfg_now.first_w;
        pairs_left_q = (cfg_now.second_w == 0) ? reps_t'(1) : {cfg_now.pair_n, 1'b0};
        next_load_q  = actual_q;
        cd_q         = period_less(actual_q);
        pin_q        = 1'b0;
        hold_left_q  = '0;
        active_q     = 1'b1;
      end
      CMD_PRESET: begin
        clamped = pos;
        if (clamped < cfg_now.min_w) clamped = cfg_now.min_w;
        else if (clamped > cfg_now.max_w) clamped = cfg_now.max_w;
        actual_q = clamped;
      end
      default: ;
    endcase
    r.pin     = pin_q;
    r.running = active_q;
    r.actual  = actual_q;
    r.target  = target_q;
    return r;
  endfunction

  // Offer one beat, wait for it to be taken, record its prediction
  task automatic send_beat(input logic [CmdBits-1:0] cmd, input width_t pos);
    in_ch.valid         <= 1'b1;
    in_ch.cmd           <= cmd;
    in_ch.position_clks <= pos;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    awaited_servo_states.push_back(step_servo(cmd, pos));
    beats_sent++;
    if (gaps_on) begin
      if (burst_left == 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                 : $urandom_range(1, 10);
      end else begin
        burst_left--;
      end
    end
  endtask

  // Stop offering beats and let every pending result come out
  task automatic drain_pipeline();
    in_ch.valid <= 1'b0;
    while (awaited_servo_states.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write all eight registers, one per edge; only called with the pipeline drained
  task automatic program_regs(input servo_cfg_t c);
    width_t word;
    for (int i = 0; i < 8; i++) begin
      case (reg_idx_e'(i))
        REG_PERIOD: word = c.period_w;
        REG_STEP:   word = c.step_w;
        REG_HOLD:   word = width_t'(c.hold_n);
        REG_MIN:    word = c.min_w;
        REG_MAX:    word = c.max_w;
        REG_FIRST:  word = c.first_w;
        REG_SECOND: word = c.second_w;
        default:    word = width_t'(c.pair_n);
      endcase
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= reg_idx_e'(i);
      cfg_data_i <= word;
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    cfg_now = c;
  endtask

  function automatic width_t rand_position();
    return ($urandom_range(0, 3) == 0) ? width_t'($urandom) : width_t'($urandom_range(0, 24));
  endfunction

  function automatic width_t pick_width(input int unsigned top);
    return ($urandom_range(0, 11) == 0) ? '1 : width_t'($urandom_range(0, top));
  endfunction

  // Reset defaults: idle ticks, the ignored command, clamped presets, then a start and a tick
  task automatic test_idle_and_presets();
    send_beat(CMD_TICK, '1);
    send_beat(CmdIgnored, '0);
    send_beat(CMD_PRESET, '0);
    send_beat(CMD_PRESET, '1);
    send_beat(CMD_PRESET, width_t'(7000));
    send_beat(CMD_START, '0);
    send_beat(CMD_TICK, '0);
  endtask

  // Every register at its top value, then period at one and every other register at zero
  task automatic test_register_extremes();
    drain_pipeline();
    program_regs('{'1, '1, '1, '1, '1, '1, '1, '1});
    send_beat(CMD_PRESET, '0);
    send_beat(CMD_START, '1);
    send_beat(CMD_TICK, '0);
    drain_pipeline();
    // zero step and zero hold: runs on until restarted
    program_regs('{width_t'(1), '0, '0, '0, '0, '0, '0, '0});
    send_beat(CMD_PRESET, '1);
    send_beat(CMD_START, '0);
    repeat (4) send_beat(CMD_TICK, '0);
  endtask

  // Min above max, zero repeats with a second width, preset and restart while active
  task automatic test_special_cases();
    drain_pipeline();
    program_regs('{width_t'(4), width_t'(2), hold_t'(1), width_t'(6), width_t'(3),
                   width_t'(5), width_t'(1), rep_t'(0)});
    send_beat(CMD_PRESET, width_t'(2));
    send_beat(CMD_PRESET, width_t'(7));
    send_beat(CMD_START, '0);
    repeat (4) send_beat(CMD_TICK, '0);
    send_beat(CMD_PRESET, width_t'(9));
    send_beat(CMD_START, '0);
    repeat (12) send_beat(CMD_TICK, '0);
  endtask

  // Receiver holds off for a long stretch while beats keep coming
  task automatic test_backpressure();
    drain_pipeline();
    program_regs('{width_t'(6), width_t'(1), hold_t'(1), width_t'(0), width_t'(20),
                   width_t'(4), width_t'(2), rep_t'(2)});
    gaps_on = 1'b0;
    hold_off_left = 150;
    send_beat(CMD_PRESET, width_t'(1));
    send_beat(CMD_START, '0);
    repeat (40) send_beat(CMD_TICK, rand_position());
    gaps_on = 1'b1;
  endtask

  // Random settings; mostly preset, start and a run of ticks, with some noise
  task automatic test_random_sequences();
    servo_cfg_t  c;
    int unsigned goal;
    int unsigned roll;
    goal = TotalBeats;
    while (beats_sent < goal) begin
      drain_pipeline();
      c.period_w = ($urandom_range(0, 11) == 0) ? '1 : width_t'($urandom_range(1, 24));
      c.step_w   = pick_width(5);
      c.hold_n   = ($urandom_range(0, 15) == 0) ? '1 : hold_t'($urandom_range(0, 3));
      c.min_w    = pick_width(12);
      c.max_w    = pick_width(24);
      c.first_w  = pick_width(20);
      c.second_w = ($urandom_range(0, 4) == 0) ? '0 : pick_width(20);
      c.pair_n   = ($urandom_range(0, 14) == 0) ? '1 : rep_t'($urandom_range(0, 3));
      program_regs(c);
      send_beat(CMD_PRESET, rand_position());
      send_beat(CMD_START, width_t'($urandom));
      repeat ($urandom_range(30, 140)) begin
        if (beats_sent >= goal) break;
        roll = $urandom_range(0, 99);
        if (roll < 88) send_beat(CMD_TICK, width_t'($urandom));
        else if (roll < 93) send_beat(CMD_PRESET, rand_position());
        else if (roll < 96) send_beat(CmdIgnored, width_t'($urandom));
        else send_beat(CMD_START, width_t'($urandom));
      end
    end
  endtask

  // Receiver: check each result beat, then choose ready for the next edge
  initial begin
    servo_beat_t want, seen;
    sink_mode_e  mode;
    int unsigned mode_left;
    mode = SINK_OPEN;
    mode_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_ch.valid && out_ch.ready) begin
        seen.pin     = out_ch.pin_level;
        seen.running = out_ch.running;
        seen.actual  = out_ch.actual_width_clks;
        seen.target  = out_ch.target_width_clks;
        if (awaited_servo_states.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result beat: pin=%0b run=%0b actual=%0d target=%0d",
                     seen.pin, seen.running, seen.actual, seen.target);
        end else begin
          want = awaited_servo_states.pop_front();
          if (seen.pin !== want.pin || seen.running !== want.running ||
              seen.actual !== want.actual || seen.target !== want.target) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("result beat differs: want pin=%0b run=%0b actual=%0d target=%0d, %s",
                       want.pin, want.running, want.actual, want.target,
                       $sformatf("got pin=%0b run=%0b actual=%0d target=%0d",
                                 seen.pin, seen.running, seen.actual, seen.target));
          end
        end
      end
      if (hold_off_left > 0) begin
        hold_off_left--;
        out_ch.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = sink_mode_e'($urandom_range(0, 2));
          mode_left = $urandom_range(10, 80);
        end
        mode_left--;
        case (mode)
          SINK_OPEN: out_ch.ready <= 1'b1;
          SINK_BUSY: out_ch.ready <= ($urandom_range(0, 3) != 0);
          default:   out_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Main sequence
  initial begin
    rst_ni              <= 1'b0;
    cfg_we_i            <= 1'b0;
    cfg_idx_i           <= REG_PERIOD;
    cfg_data_i          <= '0;
    in_ch.valid         <= 1'b0;
    in_ch.cmd           <= CMD_TICK;
    in_ch.position_clks <= '0;
    cfg_now = '{RstPeriod, RstStep, RstHold, RstMin, RstMax, RstFirst, RstSecond, RstRepeat};
    cd_q = '0;
    next_load_q = '0;
    actual_q = '0;
    target_q = '0;
    hold_left_q = '0;
    pairs_left_q = '0;
    pin_q = 1'b0;
    active_q = 1'b0;
    mismatch_count = 0;
    beats_sent = 0;
    cycle_count = 0;
    burst_left = 0;
    hold_off_left = 0;
    gaps_on = 1'b1;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_idle_and_presets();
    test_register_extremes();
    test_special_cases();
    test_backpressure();
    test_random_sequences();

    drain_pipeline();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0 && awaited_servo_states.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
